// ----- hw/rtl/weighted_moving_average_unit_macros.svh -----
// Assertion macros for the weighted moving average unit checker.
`ifndef WEIGHTED_MOVING_AVERAGE_UNIT_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define WMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define WMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define WMA_ASSERT_RST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/wma_pkg.sv -----
// Shared constants and controller/datapath interface types for the averaging unit.
`default_nettype none

package wma_pkg;

  localparam int WINDOW       = 8;
  localparam int NUM_WEIGHTS  = 8;
  localparam int SAMPLE_W     = 32;
  localparam int WEIGHT_W     = 8;
  localparam int WT_W         = 11;
  localparam int CFG_IDX_W    = 4;
  localparam int RING_AW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int POS_W        = RING_AW;
  localparam int FILL_W       = $clog2(WINDOW + 1);
  localparam int WIDX_W       = $clog2(NUM_WEIGHTS);
  localparam int USED_WEIGHTS = (WINDOW < NUM_WEIGHTS) ? WINDOW : NUM_WEIGHTS;
  localparam int WT_RESET     = USED_WEIGHTS;
  localparam int PROD_W       = SAMPLE_W + WEIGHT_W + 1;
  localparam int ACC_W        = 44;
  localparam int REM_W        = WT_W + 1;
  localparam int DIV_STEPS    = ACC_W / 2;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic store;
    logic mac_issue;
    logic div_init;
    logic div_step;
    logic commit;
    logic out_load;
  } wma_cmd_t;

  typedef struct packed {
    logic full;
    logic wt_zero;
    logic last_issue;
    logic mac_busy;
    logic div_last;
  } wma_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wma_datapath.sv -----
// Datapath: weight registers, sample ring, multiply-accumulate pipe, divider, result registers.
`default_nettype none

module wma_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire wma_pkg::wma_cmd_t                    cmd,
  output wma_pkg::wma_status_t                      status,
  input  wire logic signed [wma_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic                                 cfg_we,
  input  wire logic        [wma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [wma_pkg::WEIGHT_W-1:0]  cfg_data,
  output logic signed      [wma_pkg::SAMPLE_W-1:0]  average,
  output logic                                      window_full,
  output logic                                      weight_sum_zero
);

  logic [wma_pkg::WEIGHT_W-1:0] weight [wma_pkg::NUM_WEIGHTS];
  logic [wma_pkg::WT_W-1:0]     weight_total;

  logic [wma_pkg::SAMPLE_W-1:0] ring [wma_pkg::WINDOW];
  logic [wma_pkg::RING_AW-1:0]  write_slot;
  logic [wma_pkg::RING_AW-1:0]  slot_next;
  logic [wma_pkg::RING_AW-1:0]  rd_ptr;
  logic [wma_pkg::RING_AW-1:0]  ptr_inc;
  logic [wma_pkg::FILL_W-1:0]   fill_count;
  logic [wma_pkg::POS_W-1:0]    pos;

  logic [wma_pkg::WEIGHT_W-1:0]       wt_pos;
  logic [wma_pkg::WEIGHT_W-1:0]       wt_q;
  logic signed [wma_pkg::SAMPLE_W-1:0] rd_data;
  logic                               rd_vld;
  logic signed [wma_pkg::PROD_W-1:0]  prod;
  logic                               prod_vld;
  logic signed [wma_pkg::ACC_W-1:0]   acc;

  logic [wma_pkg::REM_W-1:0]    rem;
  logic [wma_pkg::REM_W-1:0]    rem_next;
  logic [wma_pkg::ACC_W-1:0]    quo;
  logic [wma_pkg::ACC_W-1:0]    quo_next;
  logic [wma_pkg::REM_W-1:0]    rt;
  logic [wma_pkg::ACC_W-1:0]    qt;
  logic [wma_pkg::REM_W-1:0]    tt;
  logic                         neg;
  logic [wma_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [wma_pkg::SAMPLE_W-1:0] q32;
  logic [wma_pkg::SAMPLE_W-1:0] held_average;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wma_pkg::NUM_WEIGHTS; i++) begin
        weight[i] <= wma_pkg::WEIGHT_W'(1);
      end
      weight_total <= wma_pkg::WT_W'(wma_pkg::WT_RESET);
    end else if (cfg_we && (cfg_index < wma_pkg::CFG_IDX_W'(wma_pkg::NUM_WEIGHTS))) begin
      weight[cfg_index[wma_pkg::WIDX_W-1:0]] <= cfg_data;
      if (cfg_index < wma_pkg::CFG_IDX_W'(wma_pkg::USED_WEIGHTS)) begin
        weight_total <= weight_total
                        - wma_pkg::WT_W'(weight[cfg_index[wma_pkg::WIDX_W-1:0]])
                        + wma_pkg::WT_W'(cfg_data);
      end
    end
  end

  assign slot_next = (write_slot == wma_pkg::RING_AW'(wma_pkg::WINDOW - 1)) ?
                     '0 : write_slot + 1'b1;
  assign ptr_inc   = (rd_ptr == wma_pkg::RING_AW'(wma_pkg::WINDOW - 1)) ?
                     '0 : rd_ptr + 1'b1;

  always_comb begin
    wt_pos = '0;
    if (int'(pos) < wma_pkg::USED_WEIGHTS) begin
      wt_pos = weight[wma_pkg::WIDX_W'(pos)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      ring[write_slot] <= sample;
    end
    if (cmd.mac_issue) begin
      rd_data <= ring[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      rd_ptr     <= '0;
      pos        <= '0;
      rd_vld     <= 1'b0;
      prod_vld   <= 1'b0;
    end else begin
      rd_vld   <= cmd.mac_issue;
      prod_vld <= rd_vld;
      if (cmd.store) begin
        write_slot <= slot_next;
        rd_ptr     <= slot_next;
        pos        <= '0;
        if (fill_count != wma_pkg::FILL_W'(wma_pkg::WINDOW)) begin
          fill_count <= fill_count + 1'b1;
        end
      end else if (cmd.mac_issue) begin
        rd_ptr <= ptr_inc;
        pos    <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_issue) begin
      wt_q <= wt_pos;
    end
    prod <= wma_pkg::PROD_W'(rd_data) * wma_pkg::PROD_W'($signed({1'b0, wt_q}));
    if (cmd.store) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + {{(wma_pkg::ACC_W - wma_pkg::PROD_W){prod[wma_pkg::PROD_W-1]}}, prod};
    end
  end

  always_comb begin
    rt = rem;
    qt = quo;
    tt = '0;
    for (int k = 0; k < 2; k++) begin
      tt = {rt[wma_pkg::REM_W-2:0], qt[wma_pkg::ACC_W-1]};
      qt = {qt[wma_pkg::ACC_W-2:0], 1'b0};
      if (tt >= {1'b0, weight_total}) begin
        tt    = tt - {1'b0, weight_total};
        qt[0] = 1'b1;
      end
      rt = tt;
    end
    rem_next = rt;
    quo_next = qt;
  end

  assign q32 = quo[wma_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg     <= acc[wma_pkg::ACC_W-1];
      quo     <= acc[wma_pkg::ACC_W-1] ? -acc : acc;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_next;
      quo     <= quo_next;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_average <= '0;
    end else if (cmd.commit) begin
      held_average <= neg ? -q32 : q32;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average         <= held_average;
      window_full     <= status.full;
      weight_sum_zero <= status.wt_zero;
    end
  end

  assign status.full       = (fill_count == wma_pkg::FILL_W'(wma_pkg::WINDOW));
  assign status.wt_zero    = (weight_total == '0);
  assign status.last_issue = (pos == wma_pkg::POS_W'(wma_pkg::WINDOW - 1));
  assign status.mac_busy   = rd_vld | prod_vld;
  assign status.div_last   = (div_cnt == wma_pkg::DIV_CNT_W'(wma_pkg::DIV_STEPS - 1));

endmodule

`default_nettype wire

// ----- hw/rtl/wma_ctrl.sv -----
// Controller state machine: sequences store, accumulate, divide and result handoff.
`default_nettype none

module wma_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire wma_pkg::wma_status_t status,
  output wma_pkg::wma_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_MAC     = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_DIVINIT = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_COMMIT  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = (status.full && !status.wt_zero) ? S_MAC : S_DONE;
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (status.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.mac_busy) begin
          state_next = S_DIVINIT;
        end
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/weighted_moving_average_unit.sv -----
// Top level of the weighted moving average unit.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    sample
//   out      output     out_valid / out_ready  average, window_full, weight_sum_zero
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An averaging request runs through the check, 8 multiply-accumulate issues, a drain
// of the read and product registers, divider setup, divider steps at two quotient bits
// each across the 44-bit accumulator, commit and output load. A holding request goes
// from the check straight to the output load. The input reopens after the result loads.
// Synchronous reset clears control, weights to 1 and the held average to 0.
// A waiting result does not block the next request; a finished one stalls only if
// the previous result is still held.
`default_nettype none

module weighted_moving_average_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [wma_pkg::SAMPLE_W-1:0]  sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed      [wma_pkg::SAMPLE_W-1:0]  average,
  output logic                                      window_full,
  output logic                                      weight_sum_zero,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [wma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [wma_pkg::WEIGHT_W-1:0]  cfg_data
);

  wma_pkg::wma_cmd_t    cmd;
  wma_pkg::wma_status_t status;

  assign cfg_ready = 1'b1;

  wma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wma_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .sample          (sample),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .average         (average),
    .window_full     (window_full),
    .weight_sum_zero (weight_sum_zero)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/wma_checker.sv -----
// Port-level checker for the weighted moving average unit, bound to the top level.
`default_nettype none

`include "weighted_moving_average_unit_macros.svh"

module wma_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [wma_pkg::SAMPLE_W-1:0] average,
  input wire logic                                window_full,
  input wire logic                                weight_sum_zero
);

  `WMA_ASSERT_RST_NXT(a_reset_clears_out, rst, !out_valid, "result valid after reset")

  `WMA_ASSERT_NXT(a_one_request_in_flight, in_valid && in_ready, !in_ready,
                  "new request taken while one is in progress")

  `WMA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(average) && $stable(window_full) &&
                  $stable(weight_sum_zero), "stalled result changed")

  `WMA_ASSERT_IMP(a_not_full_average_zero, out_valid && !window_full, average == '0,
                  "average nonzero before window filled")

endmodule

bind weighted_moving_average_unit wma_checker u_wma_checker (.*);

`default_nettype wire
